@@ sv/crcm_pkg.sv @@
// Shared types, constants and the linear-light table for the readable colour mixer.
`default_nettype none

package crcm_pkg;

  // Default number of blend steps toward the text colour.
  localparam int MIX_STEPS_DEF = 10;

  // Fraction bits of linear light and luminance.
  localparam int LUM_FRAC_BITS = 16;
  localparam int LIN_W         = LUM_FRAC_BITS + 1;

  // Weighted luminance sum plus rounding offset, and its reciprocal divide by 10000.
  localparam int SUM_W       = 30;
  localparam int RECIP_SHIFT = 43;
  localparam logic [SUM_W-1:0] LUM_RECIP =
    SUM_W'(((64'd1 << RECIP_SHIFT) + 64'd9999) / 64'd10000);

  // Width of the contrast cross-products.
  localparam int CMP_W = 25;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Shift used by the reciprocal divide in the blend.
  localparam int MIX_SHIFT = 24;

  // Colour: index 2 is red, 1 is green, 0 is blue.
  typedef logic [2:0][7:0] rgb_t;

  // Status of the queue as seen by its writer and reader.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One finished result.
  typedef struct packed {
    rgb_t       colour;
    logic [3:0] step;
    logic       met;
  } result_t;

  typedef logic [LIN_W-1:0] lin_tab_t [256];

  // Fifth power of a Q0.31 value by four truncating products.
  function automatic logic [63:0] pow5_q31(input logic [63:0] r);
    logic [63:0] a;
    a = r;
    for (int i = 0; i < 4; i++) begin
      a = (a * r) >> 31;
    end
    return a;
  endfunction

  // Builds the sRGB to linear-light table at elaboration.
  function automatic lin_tab_t build_lin_tab();
    lin_tab_t    t;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] l31;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        t[v] = LIN_W'((((64'(v) * 64'd100) << LUM_FRAC_BITS) + 64'd164730) / 64'd329460);
      end else begin
        y  = ((64'(v) * 64'd1000 + 64'd14025) << 31) / 64'd269025;
        y2 = (y * y) >> 31;
        lo = 64'd0;
        hi = 64'd1 << 31;
        for (int s = 0; s < 40; s++) begin
          if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (pow5_q31(mid) <= y2) begin
              lo = mid;
            end else begin
              hi = mid - 64'd1;
            end
          end
        end
        l31  = (y2 * lo) >> 31;
        t[v] = LIN_W'((l31 + (64'd1 << (30 - LUM_FRAC_BITS))) >> (31 - LUM_FRAC_BITS));
      end
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

  // Weighted luminance sum with the half-up rounding offset already added.
  function automatic logic [SUM_W-1:0] luma_sum(input rgb_t c);
    return SUM_W'(LIN_TAB[c[2]]) * SUM_W'(2126) +
           SUM_W'(LIN_TAB[c[1]]) * SUM_W'(7152) +
           SUM_W'(LIN_TAB[c[0]]) * SUM_W'(722) + SUM_W'(5000);
  endfunction

endpackage

`default_nettype wire

@@ sv/contrast_readable_colour_mix.sv @@
// Top level of the readable colour mixer.
//
//  Channel   Handshake          Payload
//  input     push / full        in_accent_*, in_back_*, in_fore_* (8 bits each)
//  result    pop / empty        out_red, out_green, out_blue, out_blend_step,
//                               out_met_threshold
//
// One request is taken every cycle; the input stage only stops when the queue is full.
// A request passes through the front register, the queue, three pipeline stages in the back
// and then the result buffer.
// Reset is synchronous and active low and empties every stage and buffer.
// A full result buffer halts the back pipeline, then the queue fills and full rises.
`default_nettype none

module contrast_readable_colour_mix #(
  parameter int MIX_STEPS = crcm_pkg::MIX_STEPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_accent_red,
  input  wire logic [7:0] in_accent_green,
  input  wire logic [7:0] in_accent_blue,
  input  wire logic [7:0] in_back_red,
  input  wire logic [7:0] in_back_green,
  input  wire logic [7:0] in_back_blue,
  input  wire logic [7:0] in_fore_red,
  input  wire logic [7:0] in_fore_green,
  input  wire logic [7:0] in_fore_blue,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [3:0]      out_blend_step,
  output logic            out_met_threshold
);

  localparam int EntryW = (MIX_STEPS + 2) * 24;

  crcm_pkg::rgb_t                   acc, back, fore;
  crcm_pkg::rgb_t [MIX_STEPS+1:0]   f_entry, b_entry;
  crcm_pkg::q_stat_t                q_stat;
  crcm_pkg::result_t                res;
  logic                             q_push, q_pop;

  assign acc  = {in_accent_red, in_accent_green, in_accent_blue};
  assign back = {in_back_red, in_back_green, in_back_blue};
  assign fore = {in_fore_red, in_fore_green, in_fore_blue};

  crcm_front #(.MIX_STEPS(MIX_STEPS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_acc  (acc),
    .in_back (back),
    .in_fore (fore),
    .q_push  (q_push),
    .q_entry (f_entry),
    .q_stat  (q_stat)
  );

  crcm_queue #(.Width(EntryW), .Depth(crcm_pkg::QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (f_entry),
    .rd_en   (q_pop),
    .rd_data (b_entry),
    .stat    (q_stat)
  );

  crcm_back #(.MIX_STEPS(MIX_STEPS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_entry (b_entry),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign out_red           = res.colour[2];
  assign out_green         = res.colour[1];
  assign out_blue          = res.colour[0];
  assign out_blend_step    = res.step;
  assign out_met_threshold = res.met;

endmodule

`default_nettype wire

@@ sv/crcm_queue.sv @@
// Short request queue between the front and back halves.
`default_nettype none

module crcm_queue #(
  parameter int Width = 8,
  parameter int Depth = crcm_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [Width-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [Width-1:0] rd_data,
  output crcm_pkg::q_stat_t     stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign do_wr = wr_en && (cnt_r != CntW'(Depth));
  assign do_rd = rd_en && (cnt_r != '0);

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage has no reset; only entries counted as full are ever read.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data    = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == CntW'(Depth));
  assign stat.empty = (cnt_r == '0);

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Depth)) else $error("queue count beyond depth");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + CntW'(1)))
    else $error("queue count did not follow a write");
  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("empty queue with split pointers");
`endif

endmodule

`default_nettype wire

@@ sv/crcm_front.sv @@
// Front half: takes requests and forms every blend candidate.
`default_nettype none

module crcm_front #(
  parameter int MIX_STEPS = crcm_pkg::MIX_STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire crcm_pkg::rgb_t    in_acc,
  input  wire crcm_pkg::rgb_t    in_back,
  input  wire crcm_pkg::rgb_t    in_fore,
  output logic                   q_push,
  output crcm_pkg::rgb_t [MIX_STEPS+1:0] q_entry,
  input  wire crcm_pkg::q_stat_t q_stat
);

  localparam int Lanes    = MIX_STEPS + 1;
  localparam int MagW     = 8 + $clog2(MIX_STEPS + 1);
  localparam int XW       = MagW + 1;
  localparam int PW       = XW + crcm_pkg::MIX_SHIFT;
  localparam int MixRecip = ((1 << crcm_pkg::MIX_SHIFT) + 2 * MIX_STEPS - 1) / (2 * MIX_STEPS);

  logic                            sa_v_r;
  crcm_pkg::rgb_t                  sa_acc_r, sa_back_r;
  logic [Lanes-1:0][2:0][MagW-1:0] sa_mag_r, sa_mag_nxt;
  logic [2:0]                      sa_neg_r, sa_neg_nxt;
  logic                            a_load;

  // Stage takes a request when empty or when the queue has room for its contents.
  assign a_load = !sa_v_r || !q_stat.full;
  assign full   = !a_load;
  assign q_push = sa_v_r && !q_stat.full;

  // Distance to the text colour, scaled by each step count.
  always_comb begin
    logic [7:0] diff;
    for (int c = 0; c < 3; c++) begin
      sa_neg_nxt[c] = in_fore[c] < in_acc[c];
      diff = sa_neg_nxt[c] ? (in_acc[c] - in_fore[c]) : (in_fore[c] - in_acc[c]);
      for (int l = 0; l < Lanes; l++) begin
        sa_mag_nxt[l][c] = MagW'(diff) * MagW'(l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
    end else if (a_load) begin
      sa_v_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      sa_acc_r  <= in_acc;
      sa_back_r <= in_back;
      sa_mag_r  <= sa_mag_nxt;
      sa_neg_r  <= sa_neg_nxt;
    end
  end

  // Rounded blend, half away from zero, via a reciprocal multiply.
  always_comb begin
    logic [XW-1:0] x;
    logic [PW-1:0] prod;
    logic [7:0]    q;
    for (int l = 0; l < Lanes; l++) begin
      for (int c = 0; c < 3; c++) begin
        x    = XW'({sa_mag_r[l][c], 1'b0}) + XW'(MIX_STEPS);
        prod = PW'(x) * PW'(MixRecip);
        q    = prod[crcm_pkg::MIX_SHIFT +: 8];
        q_entry[l][c] = sa_neg_r[c] ? (sa_acc_r[c] - q) : (sa_acc_r[c] + q);
      end
    end
    q_entry[Lanes] = sa_back_r;
  end

endmodule

`default_nettype wire

@@ sv/crcm_back.sv @@
// Back half: luminance of every candidate, contrast test and choice of the first that passes.
`default_nettype none

module crcm_back #(
  parameter int MIX_STEPS = crcm_pkg::MIX_STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire crcm_pkg::rgb_t [MIX_STEPS+1:0] q_entry,
  input  wire crcm_pkg::q_stat_t q_stat,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output crcm_pkg::result_t      res
);

  localparam int Lanes = MIX_STEPS + 1;
  localparam int YW    = crcm_pkg::LIN_W;
  localparam int CW    = crcm_pkg::CMP_W;
  localparam int PW    = 2 * crcm_pkg::SUM_W;

  logic                                   en;
  logic                                   p1_v_r, p2_v_r, p3_v_r;
  crcm_pkg::rgb_t [Lanes:0]               p1_col_r;
  logic [Lanes:0][crcm_pkg::SUM_W-1:0]    p1_x_r, p1_x_nxt;
  crcm_pkg::rgb_t [Lanes:0]               p2_col_r;
  logic [Lanes:0][YW-1:0]                 p2_y_r, p2_y_nxt;
  crcm_pkg::rgb_t [Lanes-1:0]             p3_col_r;
  logic [Lanes-1:0]                       p3_pass_r, p3_pass_nxt;
  crcm_pkg::result_t                      sel;

  crcm_pkg::result_t of_mem [2];
  logic              of_wr_r, of_rd_r;
  logic [1:0]        of_cnt_r, of_cnt_nxt;
  logic              of_full, of_push, of_pop;

  // The pipeline moves as one and stops only when its last stage cannot hand over.
  assign of_full = (of_cnt_r == 2'd2);
  assign en      = !(p3_v_r && of_full);
  assign q_pop   = en && !q_stat.empty;
  assign of_push = p3_v_r && !of_full;
  assign of_pop  = pop && (of_cnt_r != 2'd0);

  // Weighted sums from the linear-light table.
  always_comb begin
    for (int l = 0; l <= Lanes; l++) begin
      p1_x_nxt[l] = crcm_pkg::luma_sum(q_entry[l]);
    end
  end

  // Divide by 10000 through the reciprocal.
  always_comb begin
    logic [PW-1:0] prod;
    for (int l = 0; l <= Lanes; l++) begin
      prod        = PW'(p1_x_r[l]) * PW'(crcm_pkg::LUM_RECIP);
      p2_y_nxt[l] = prod[crcm_pkg::RECIP_SHIFT +: YW];
    end
  end

  // Contrast test by cross-multiplication against the background.
  always_comb begin
    logic [YW-1:0] ymax, ymin;
    logic [CW-1:0] lhs, rhs;
    for (int l = 0; l < Lanes; l++) begin
      ymax = (p2_y_r[l] > p2_y_r[Lanes]) ? p2_y_r[l] : p2_y_r[Lanes];
      ymin = (p2_y_r[l] > p2_y_r[Lanes]) ? p2_y_r[Lanes] : p2_y_r[l];
      lhs  = CW'(2) * (CW'(ymax) * CW'(20) + (CW'(1) << crcm_pkg::LUM_FRAC_BITS));
      rhs  = CW'(9) * (CW'(ymin) * CW'(20) + (CW'(1) << crcm_pkg::LUM_FRAC_BITS));
      p3_pass_nxt[l] = lhs >= rhs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= q_pop;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_col_r  <= q_entry;
      p1_x_r    <= p1_x_nxt;
      p2_col_r  <= p1_col_r;
      p2_y_r    <= p2_y_nxt;
      p3_col_r  <= p2_col_r[Lanes-1:0];
      p3_pass_r <= p3_pass_nxt;
    end
  end

  // Lowest passing step wins; the last lane is the text colour for the fallback.
  always_comb begin
    sel.colour = p3_col_r[Lanes-1];
    sel.step   = 4'(MIX_STEPS);
    sel.met    = 1'b0;
    for (int l = Lanes - 1; l >= 0; l--) begin
      if (p3_pass_r[l]) begin
        sel.colour = p3_col_r[l];
        sel.step   = 4'(l);
        sel.met    = 1'b1;
      end
    end
  end

  // Two-entry result buffer.
  always_comb begin
    of_cnt_nxt = of_cnt_r;
    if (of_push && !of_pop) begin
      of_cnt_nxt = of_cnt_r + 2'd1;
    end else if (of_pop && !of_push) begin
      of_cnt_nxt = of_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_r  <= 1'b0;
      of_rd_r  <= 1'b0;
      of_cnt_r <= 2'd0;
    end else begin
      of_cnt_r <= of_cnt_nxt;
      if (of_push) begin
        of_wr_r <= !of_wr_r;
      end
      if (of_pop) begin
        of_rd_r <= !of_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (of_push) begin
      of_mem[of_wr_r] <= sel;
    end
  end

  assign res   = of_mem[of_rd_r];
  assign empty = (of_cnt_r == 2'd0);

`ifndef ASSERT_OFF
  a_of_bound: assert property (@(posedge clk) disable iff (!rst_n)
    of_cnt_r <= 2'd2) else $error("result buffer over depth");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p3_v_r && of_full) |=> p3_v_r) else $error("stalled result lost");
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    (of_push && !sel.met) |-> (sel.step == 4'(MIX_STEPS)))
    else $error("fallback with wrong step");
  a_pop_source: assert property (@(posedge clk) disable iff (!rst_n)
    (en && q_pop) |=> p1_v_r) else $error("popped request not in pipeline");
`endif

endmodule

`default_nettype wire

@@ sim/tb_contrast_readable_colour_mix.sv @@
// Testbench for the readable colour mixer: directed and random colour triples checked against a predictor.
`timescale 1ns / 1ps

module tb_contrast_readable_colour_mix;

  localparam int STEPS      = crcm_pkg::MIX_STEPS_DEF;
  localparam int FRAC       = crcm_pkg::LUM_FRAC_BITS;
  localparam int NUM_RANDOM = 1930;
  localparam int CYCLE_CAP  = 2000000;

  typedef struct {
    logic [7:0] acc [3];
    logic [7:0] back [3];
    logic [7:0] fore [3];
  } colour_req_t;

  typedef struct {
    logic [7:0] chan [3];
    logic [3:0] step;
    logic       met;
  } readable_t;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic       empty;
  logic       pop;
  logic [7:0] in_acc [3];
  logic [7:0] in_back [3];
  logic [7:0] in_fore [3];
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [3:0] out_blend_step;
  logic       out_met_threshold;

  colour_req_t pending_reqs [$];
  readable_t   expected_colours [$];
  longint      lin_light [256];
  int          mismatches;
  int          cycles;
  logic        took;
  int          push_gap;
  int          pop_gap;

  contrast_readable_colour_mix uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_accent_red(in_acc[0]), .in_accent_green(in_acc[1]), .in_accent_blue(in_acc[2]),
    .in_back_red(in_back[0]), .in_back_green(in_back[1]), .in_back_blue(in_back[2]),
    .in_fore_red(in_fore[0]), .in_fore_green(in_fore[1]), .in_fore_blue(in_fore[2]),
    .empty(empty), .pop(pop), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_blend_step(out_blend_step),
    .out_met_threshold(out_met_threshold)
  );

  // Fifth power in Q0.31 with a truncation after every product.
  function automatic longint unsigned fifth_power(input longint unsigned r);
    longint unsigned acc;
    acc = r;
    repeat (4) acc = (acc * r) >> 31;
    return acc;
  endfunction

  // Linear light of one 8-bit sRGB channel in Q1.16.
  function automatic longint srgb_to_linear(input int v);
    longint unsigned y;
    longint unsigned y2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (v <= 10) begin
      return ((longint'(v) * 100 << FRAC) + 164730) / 329460;
    end
    y  = ((longint'(v) * 1000 + 14025) << 31) / 269025;
    y2 = (y * y) >> 31;
    lo = 0;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (fifth_power(mid) <= y2) lo = mid;
      else hi = mid - 1;
    end
    return ((((y2 * lo) >> 31) + (64'd1 << (30 - FRAC))) >> (31 - FRAC));
  endfunction

  function automatic longint luminance(input logic [7:0] c [3]);
    longint s;
    s = 2126 * lin_light[c[0]] + 7152 * lin_light[c[1]] + 722 * lin_light[c[2]];
    return (s + 5000) / 10000;
  endfunction

  // Contrast of at least 4.5, tested by cross-multiplication.
  function automatic bit contrast_ok(input logic [7:0] c [3], input longint yb);
    longint yc;
    longint hi_y;
    longint lo_y;
    yc   = luminance(c);
    hi_y = (yc > yb) ? yc : yb;
    lo_y = (yc > yb) ? yb : yc;
    return 2 * (20 * hi_y + (64'd1 << FRAC)) >= 9 * (20 * lo_y + (64'd1 << FRAC));
  endfunction

  // Channel a moved k steps toward b, rounded half away from zero.
  function automatic logic [7:0] mix_channel(input int a, input int b, input int k);
    int q;
    if (b >= a) begin
      q = (2 * (b - a) * k + STEPS) / (2 * STEPS);
      return 8'(a + q);
    end
    q = (2 * (a - b) * k + STEPS) / (2 * STEPS);
    return 8'(a - q);
  endfunction

  function automatic readable_t choose_colour(input colour_req_t r);
    readable_t  res;
    logic [7:0] mixed [3];
    longint     yb;
    yb = luminance(r.back);
    if (contrast_ok(r.acc, yb)) begin
      res.chan = r.acc;
      res.step = 4'd0;
      res.met  = 1'b1;
      return res;
    end
    for (int k = 1; k <= STEPS; k++) begin
      for (int i = 0; i < 3; i++) mixed[i] = mix_channel(r.acc[i], r.fore[i], k);
      if (contrast_ok(mixed, yb)) begin
        res.chan = mixed;
        res.step = 4'(k);
        res.met  = 1'b1;
        return res;
      end
    end
    res.chan = r.fore;
    res.step = 4'(STEPS);
    res.met  = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic queue_request(input logic [7:0] a [3], input logic [7:0] b [3],
                               input logic [7:0] f [3]);
    colour_req_t r;
    r.acc  = a;
    r.back = b;
    r.fore = f;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  // Prediction on each accepted request, and checking of each accepted result.
  always @(posedge clk) begin
    colour_req_t r;
    readable_t   want;
    took <= rst_n && push && !full;
    if (rst_n && push && !full) begin
      r.acc  = in_acc;
      r.back = in_back;
      r.fore = in_fore;
      expected_colours.insert(expected_colours.size(), choose_colour(r));
    end
    if (rst_n && pop && !empty) begin
      if (expected_colours.size() == 0) begin
        report_mismatch("result with no request outstanding", 1, 0);
      end else begin
        want = expected_colours.pop_front();
        if (out_red !== want.chan[0]) report_mismatch("red", out_red, want.chan[0]);
        if (out_green !== want.chan[1]) report_mismatch("green", out_green, want.chan[1]);
        if (out_blue !== want.chan[2]) report_mismatch("blue", out_blue, want.chan[2]);
        if (out_blend_step !== want.step)
          report_mismatch("blend step", out_blend_step, want.step);
        if (out_met_threshold !== want.met)
          report_mismatch("threshold flag", out_met_threshold, want.met);
      end
    end
  end

  // Request driver, fed from the pending queue.
  always @(negedge clk) begin
    int gap;
    gap = push_gap;
    if (took) begin
      void'(pending_reqs.pop_front());
      gap = pick_gap((cycles / 3000) % 4 == 1);
    end
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !took) begin
      // The current request is still waiting, so it is held unchanged.
      push <= 1'b1;
    end else if (gap != 0) begin
      push     <= 1'b0;
      push_gap <= gap - 1;
    end else if (pending_reqs.size() > 0) begin
      push     <= 1'b1;
      push_gap <= 0;
      in_acc   <= pending_reqs[0].acc;
      in_back  <= pending_reqs[0].back;
      in_fore  <= pending_reqs[0].fore;
    end else begin
      push     <= 1'b0;
      push_gap <= 0;
    end
  end

  // Result stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_gap != 0) begin
      pop_gap <= pop_gap - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      pop_gap <= pick_gap((cycles / 2500) % 4 == 2);
    end
  end

  initial begin
    logic [7:0] a [3];
    logic [7:0] b [3];
    logic [7:0] f [3];
    int         mode;
    int         grey;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    push_gap = 0;
    pop_gap = 0;
    took = 1'b0;
    mismatches = 0;
    cycles = 0;
    for (int i = 0; i < 3; i++) begin
      in_acc[i] = 8'd0;
      in_back[i] = 8'd0;
      in_fore[i] = 8'd0;
    end
    for (int v = 0; v < 256; v++) lin_light[v] = srgb_to_linear(v);

    // Directed: extremes, the knee of the sRGB curve, blends and the text fallback.
    queue_request('{0, 0, 0}, '{255, 255, 255}, '{0, 0, 0});
    queue_request('{255, 255, 255}, '{0, 0, 0}, '{255, 255, 255});
    queue_request('{255, 255, 255}, '{255, 255, 255}, '{0, 0, 0});
    queue_request('{0, 0, 0}, '{0, 0, 0}, '{255, 255, 255});
    queue_request('{10, 10, 10}, '{11, 11, 11}, '{255, 255, 255});
    queue_request('{11, 10, 11}, '{255, 255, 255}, '{10, 11, 10});
    queue_request('{128, 128, 128}, '{128, 128, 128}, '{128, 128, 128});
    queue_request('{118, 118, 118}, '{119, 119, 119}, '{120, 120, 120});
    queue_request('{255, 0, 0}, '{255, 255, 255}, '{0, 0, 0});
    queue_request('{0, 255, 0}, '{255, 255, 255}, '{0, 0, 0});
    queue_request('{0, 0, 255}, '{0, 0, 0}, '{255, 255, 255});
    queue_request('{200, 30, 170}, '{250, 250, 250}, '{20, 20, 20});
    queue_request('{30, 200, 90}, '{10, 10, 10}, '{240, 240, 240});
    queue_request('{255, 0, 255}, '{128, 128, 128}, '{0, 255, 0});
    queue_request('{5, 250, 5}, '{118, 118, 118}, '{250, 5, 250});
    queue_request('{170, 85, 170}, '{85, 170, 85}, '{255, 255, 255});
    queue_request('{1, 2, 4}, '{8, 16, 32}, '{64, 128, 255});
    queue_request('{254, 253, 251}, '{247, 239, 223}, '{191, 127, 0});

    // Random: three in ten draws use a light or dark text colour so that blends do the work.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
        a[i] = 8'($urandom_range(0, 255));
        b[i] = 8'($urandom_range(0, 255));
        f[i] = 8'($urandom_range(0, 255));
      end
      if (mode < 3) begin
        grey = $urandom_range(0, 1) ? $urandom_range(0, 30) : $urandom_range(225, 255);
        for (int i = 0; i < 3; i++) f[i] = 8'(grey);
      end else if (mode < 5) begin
        grey = $urandom_range(90, 160);
        for (int i = 0; i < 3; i++) begin
          b[i] = 8'(grey + $urandom_range(0, 8));
          a[i] = 8'(grey - $urandom_range(0, 20));
        end
      end else if (mode == 5) begin
        for (int i = 0; i < 3; i++) a[i] = 8'($urandom_range(0, 12));
      end
      queue_request(a, b, f);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_reqs.size() == 0 && expected_colours.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_colours.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/crcm_pkg.sv
sv/crcm_queue.sv
sv/crcm_front.sv
sv/crcm_back.sv
sv/contrast_readable_colour_mix.sv
sim/tb_contrast_readable_colour_mix.sv
